### hdl/ssds_pkg.sv
package ssds_pkg;

    // Display geometry and input width
    localparam int DIGIT_POSITIONS = 8;
    localparam int VALUE_WIDTH     = 16;

    localparam int SEL_WIDTH = 8;
    localparam int SEG_WIDTH = 7;
    localparam int POS_WIDTH = 3;

    // Divide by ten: q = (x * ceil(2^(W+4)/10)) >> (W+4), exact for any W-bit x
    localparam int RECIP_SHIFT = VALUE_WIDTH + 4;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH + 1;
    localparam int QUOT_WIDTH  = VALUE_WIDTH - 3;
    localparam logic [VALUE_WIDTH:0] DIV10_RECIP =
        (VALUE_WIDTH + 1)'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);

    localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(DIGIT_POSITIONS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_status;

    function automatic logic [SEG_WIDTH-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_WIDTH-1:0] seg;
        case (digit)
            4'd0:    seg = 7'h3f;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5b;
            4'd3:    seg = 7'h4f;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6d;
            4'd6:    seg = 7'h7d;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7f;
            4'd9:    seg = 7'h6f;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

### hdl/ssds_in_if.sv
interface ssds_in_if
    import ssds_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### hdl/ssds_out_if.sv
interface ssds_out_if
    import ssds_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [SEL_WIDTH-1:0] digit_select;
    logic [SEG_WIDTH-1:0] segments;
    logic                 last_digit;

    modport source (output valid, output digit_select, output segments,
                    output last_digit, input ready);
    modport sink   (input valid, input digit_select, input segments,
                    input last_digit, output ready);
endinterface

### hdl/ssds_ctrl.sv
module ssds_ctrl
    import ssds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.last ? ST_IDLE : ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_EMIT: begin
                // hold the digit until the output register can take it
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/ssds_datapath.sv
module ssds_datapath
    import ssds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SEL_WIDTH-1:0]   o_digit_select,
    output logic [SEG_WIDTH-1:0]   o_segments,
    output logic                   o_last_digit
);

    logic [VALUE_WIDTH-1:0] r_rest;
    logic [PROD_WIDTH-1:0]  r_prod;
    logic [POS_WIDTH-1:0]   r_pos;
    logic                   r_out_valid;
    logic [SEL_WIDTH-1:0]   r_sel;
    logic [SEG_WIDTH-1:0]   r_seg;
    logic                   r_last;

    logic [QUOT_WIDTH-1:0]  quot;
    logic [VALUE_WIDTH-1:0] quot_x10;
    logic [VALUE_WIDTH-1:0] rem_full;
    logic [3:0]             digit;
    logic                   last;

    assign quot     = r_prod[RECIP_SHIFT +: QUOT_WIDTH];
    assign quot_x10 = VALUE_WIDTH'({quot, 3'b000}) + VALUE_WIDTH'({quot, 1'b0});
    assign rem_full = r_rest - quot_x10;
    assign digit    = rem_full[3:0];
    assign last     = (quot == '0) || (r_pos == LAST_POS);

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last     = last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest <= i_value;
            r_pos  <= '0;
        end else if (i_cmd.emit) begin
            r_rest <= VALUE_WIDTH'(quot);
            r_pos  <= r_pos + POS_WIDTH'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_WIDTH'(r_rest) * PROD_WIDTH'(DIV10_RECIP);
        end
        if (i_cmd.emit) begin
            r_sel  <= SEL_WIDTH'(1) << r_pos;
            r_seg  <= seg_pattern(digit);
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digit_select = r_sel;
    assign o_segments     = r_seg;
    assign o_last_digit   = r_last;

endmodule

### hdl/seven_segment_decimal_scan.sv
// Sequence: the value is loaded in idle; each digit then takes a multiply by the
// reciprocal (ST_MUL) and an emit (ST_EMIT), which waits while the output register is full.
// A new value is accepted only after the last digit of the previous one is emitted,
// as set by the single shared divide-by-ten unit; one output register holds a digit.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and empties
// the output register.
module seven_segment_decimal_scan
    import ssds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssds_in_if.sink           i_in,
    ssds_out_if.source        o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ssds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ssds_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_in.value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_digit_select (o_out.digit_select),
        .o_segments     (o_out.segments),
        .o_last_digit   (o_out.last_digit)
    );

endmodule

### bench/seven_segment_decimal_scan_tb.sv
`timescale 1ns / 100ps

module seven_segment_decimal_scan_tb;
    import ssds_pkg::*;

    typedef struct packed {
        logic [SEL_WIDTH-1:0] digit_select;
        logic [SEG_WIDTH-1:0] segments;
        logic                 last_digit;
    } t_digit_drive;

    localparam logic [SEG_WIDTH-1:0] GLYPH [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };
    localparam int DECIMAL_BASE = 10;
    localparam int IDLE_MAX     = 15;

    logic i_clk;
    logic i_rst_n;

    ssds_in_if  in_ch ();
    ssds_out_if out_ch ();

    seven_segment_decimal_scan DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_digit_drive pending_digits [$];
    int           error_count;
    int           values_sent;
    int           digits_checked;
    int           sink_idle_max;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Expected digit drives for one value, lowest decimal digit first
    function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value);
        int unsigned  remainder;
        int unsigned  digit;
        t_digit_drive drive;
        remainder = value;
        for (int pos = 0; pos < DIGIT_POSITIONS && pos < SEL_WIDTH; pos++) begin
            if (pos != 0 && remainder == 0)
                break;
            digit                = remainder % DECIMAL_BASE;
            remainder            = remainder / DECIMAL_BASE;
            drive.digit_select   = SEL_WIDTH'(1) << pos;
            drive.segments       = GLYPH[digit];
            drive.last_digit     = (remainder == 0) || (pos == DIGIT_POSITIONS - 1);
            pending_digits.push_back(drive);
            if (drive.last_digit)
                break;
        end
    endfunction

    // Entered and left at a falling edge; valid stays high if the next request follows at once
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value, input int idle_max);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.value <= value;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predict_digits(value);
        values_sent++;
        @(negedge i_clk);
    endtask

    // Sink side: random stall before each digit drive is taken
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = $urandom_range(0, sink_idle_max);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_digit_drive want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_digits.size() == 0) begin
                $error("unexpected digit drive: select %0h segments %0h last %0b",
                       out_ch.digit_select, out_ch.segments, out_ch.last_digit);
                error_count++;
            end else begin
                want = pending_digits.pop_front();
                digits_checked++;
                if (out_ch.digit_select !== want.digit_select) begin
                    $error("digit_select: expected %0h, got %0h",
                           want.digit_select, out_ch.digit_select);
                    error_count++;
                end
                if (out_ch.segments !== want.segments) begin
                    $error("segments: expected %0h, got %0h", want.segments, out_ch.segments);
                    error_count++;
                end
                if (out_ch.last_digit !== want.last_digit) begin
                    $error("last_digit: expected %0b, got %0b",
                           want.last_digit, out_ch.last_digit);
                    error_count++;
                end
            end
        end
    end

    // Random value with a chosen number of decimal digits, so short runs are not rare
    function automatic logic [VALUE_WIDTH-1:0] value_of_digits(input int digits);
        int unsigned lo;
        int unsigned hi;
        lo = (digits == 1) ? 0 : 10 ** (digits - 1);
        hi = 10 ** digits - 1;
        if (hi > (1 << VALUE_WIDTH) - 1)
            hi = (1 << VALUE_WIDTH) - 1;
        return VALUE_WIDTH'($urandom_range(lo, hi));
    endfunction

    task automatic test_directed();
        logic [VALUE_WIDTH-1:0] corner [] = '{
            16'd0, 16'd1, 16'd5, 16'd9, 16'd10, 16'd42, 16'd99, 16'd100, 16'd808,
            16'd999, 16'd1000, 16'd1234, 16'd9999, 16'd10000, 16'd10001,
            16'd56789, 16'd60000, 16'd65535, 16'h8000, 16'haaaa, 16'h5555,
            16'd20406, 16'd34567
        };
        sink_idle_max = 3;
        foreach (corner[i])
            send_value(corner[i], 2);
    endtask

    task automatic test_digit_counts();
        sink_idle_max = IDLE_MAX;
        repeat (100)
            send_value(value_of_digits($urandom_range(1, 5)), IDLE_MAX);
    endtask

    task automatic test_full_range();
        sink_idle_max = IDLE_MAX;
        repeat (60)
            send_value(VALUE_WIDTH'($urandom), IDLE_MAX);
    endtask

    task automatic test_back_to_back();
        sink_idle_max = 0;
        repeat (50)
            send_value(value_of_digits($urandom_range(1, 5)), 0);
    endtask

    task automatic test_slow_sink();
        sink_idle_max = IDLE_MAX;
        repeat (50)
            send_value(VALUE_WIDTH'($urandom), 0);
    endtask

    task automatic drain();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_digits.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        error_count    = 0;
        values_sent    = 0;
        digits_checked = 0;
        sink_idle_max  = IDLE_MAX;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_digit_counts();
        test_full_range();
        test_back_to_back();
        test_slow_sink();
        drain();

        if (pending_digits.size() != 0) begin
            $error("%0d digit drives never arrived", pending_digits.size());
            error_count++;
        end
        $display("Sent %0d values (corners, 1 to 5 digit runs, full range) and checked %0d",
                 values_sent, digits_checked);
        $display("digit drives under random source gaps and sink stalls.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
